FILE: hdl/ihc_pkg.sv
// Shared types and constants for the indexed max-heap count tracker.
// No dependencies; used by every module of the block.
package ihc_pkg;
  localparam int MaxEntries = 1024;
  localparam int IdxW = 10;
  localparam int SizeW = 11;
  localparam int CntW = 8;
  localparam int OffW = 7;

  localparam logic [1:0] ReqInc = 2'd0;
  localparam logic [1:0] ReqDec = 2'd1;
  localparam logic [1:0] ReqOcc = 2'd2;
  localparam logic [1:0] ReqEmp = 2'd3;

  localparam logic CfgActive = 1'b0;
  localparam logic CfgOffset = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] cnt_addr;
    logic            cnt_we;
    logic [CntW-1:0] cnt_wdata;
    logic [IdxW-1:0] heap_addr;
    logic            heap_we;
    logic [IdxW-1:0] heap_wdata;
    logic [IdxW-1:0] slot_addr;
    logic            slot_we;
    logic [IdxW-1:0] slot_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [CntW-1:0] cnt_rdata;
    logic [IdxW-1:0] heap_rdata;
    logic [IdxW-1:0] slot_rdata;
  } mem_rsp_t;
endpackage

FILE: hdl/ihc_alu.sv
// Shared adder and signed comparator used by the sequencer for the count check and the sift compares.
// Depends on ihc_pkg.
module ihc_alu import ihc_pkg::*; (
  input  logic signed [CntW:0] a,
  input  logic signed [CntW:0] b,
  output logic signed [CntW:0] sum,
  output logic                 gt
);
  assign sum = a + b;
  assign gt  = a > b;
endmodule

FILE: hdl/ihc_store.sv
// Count, heap and reverse-map memories with the sweep that restores their
// reset contents. Depends on ihc_pkg.
module ihc_store import ihc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clear_req,
  input  mem_req_t req,
  output mem_rsp_t rsp,
  output logic     clearing
);
  logic [CntW-1:0] cnt_mem  [MaxEntries];
  logic [IdxW-1:0] heap_mem [MaxEntries];
  logic [IdxW-1:0] slot_mem [MaxEntries];
  logic            clr_r;
  logic [IdxW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear_req) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IdxW'(MaxEntries - 1)) clr_r <= 1'b0;
    end
  end

  // Heap slots and reverse map are held zero-based: slot k lives at address k.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      cnt_mem[clr_addr_r]  <= '0;
      heap_mem[clr_addr_r] <= clr_addr_r;
      slot_mem[clr_addr_r] <= clr_addr_r;
    end else begin
      if (req.cnt_we)  cnt_mem[req.cnt_addr]   <= req.cnt_wdata;
      if (req.heap_we) heap_mem[req.heap_addr] <= req.heap_wdata;
      if (req.slot_we) slot_mem[req.slot_addr] <= req.slot_wdata;
    end
    rsp.cnt_rdata  <= cnt_mem[req.cnt_addr];
    rsp.heap_rdata <= heap_mem[req.heap_addr];
    rsp.slot_rdata <= slot_mem[req.slot_addr];
  end

  assign clearing = clr_r;
endmodule

FILE: hdl/ihc_seq.sv
// Sequencer: precondition check, sift up or down one level at a time, and
// root readout. Depends on ihc_pkg and ihc_alu.
module ihc_seq import ihc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [1:0]             req_type,
  input  logic [IdxW-1:0]        entry_index,
  input  logic [SizeW-1:0]       active,
  input  logic [OffW-1:0]        offset,
  input  mem_rsp_t               rsp,
  output mem_req_t               req,
  output logic                   idle,
  output logic                   res_valid,
  output logic                   res_status,
  output logic signed [CntW-1:0] res_now,
  output logic [IdxW-1:0]        res_top_entry,
  output logic signed [CntW-1:0] res_top_count
);
  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_CHK, S_U0, S_U1, S_U2, S_U3,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_DS0, S_DS1,
    S_T0, S_T1, S_T2
  } state_t;

  state_t                 state_r;
  logic [1:0]             type_r;
  logic [IdxW-1:0]        idx_r, cur_r, par_r, lz_r, pe_r, le_r, re_r, ce_r, cz_r, te_r;
  logic signed [CntW-1:0] cur_cnt_r, lc_r, rc_r, now_r;
  logic                   status_r, lgtr_r;
  logic                   valid_r;
  logic [IdxW-1:0]        top_e_r;
  logic signed [CntW-1:0] top_c_r;

  logic signed [CntW:0]   alu_a, alu_b, alu_sum;
  logic                   alu_gt;
  logic signed [CntW:0]   c9, delta;
  logic                   pre_ok;
  logic [SizeW-1:0]       lz_w;
  logic [SizeW:0]         rz_w;

  ihc_alu u_alu (.a(alu_a), .b(alu_b), .sum(alu_sum), .gt(alu_gt));

  assign c9   = (CntW+1)'(signed'(rsp.cnt_rdata));
  assign lz_w = {cur_r, 1'b1};
  assign rz_w = {1'b0, lz_w} + 1'b1;

  always_comb begin
    case (type_r)
      ReqInc:  delta = (CntW+1)'(1);
      ReqDec:  delta = -(CntW+1)'(1);
      ReqOcc:  delta = -signed'({2'b00, offset});
      default: delta = signed'({2'b00, offset});
    endcase
  end

  always_comb begin
    alu_a = c9;
    alu_b = delta;
    case (state_r)
      S_U2:    begin alu_a = {cur_cnt_r[CntW-1], cur_cnt_r}; alu_b = c9; end
      S_D2:    begin alu_a = c9; alu_b = {cur_cnt_r[CntW-1], cur_cnt_r}; end
      S_D4:    begin alu_a = {lc_r[CntW-1], lc_r}; alu_b = c9; end
      S_D5:    begin
        alu_a = lgtr_r ? {lc_r[CntW-1], lc_r} : {rc_r[CntW-1], rc_r};
        alu_b = {cur_cnt_r[CntW-1], cur_cnt_r};
      end
      default: ;
    endcase
  end

  // The sum must stay within the count range; each type adds its own guard.
  always_comb begin
    pre_ok = (alu_sum[CntW] == alu_sum[CntW-1]);
    case (type_r)
      ReqInc:  pre_ok = pre_ok && (rsp.cnt_rdata != '1);
      ReqDec:  pre_ok = pre_ok && (rsp.cnt_rdata != '0);
      ReqOcc:  pre_ok = pre_ok && !rsp.cnt_rdata[CntW-1];
      default: pre_ok = pre_ok && rsp.cnt_rdata[CntW-1];
    endcase
  end

  always_comb begin
    req = '0;
    case (state_r)
      S_RD:  begin req.cnt_addr = idx_r; req.slot_addr = idx_r; end
      S_CHK: begin
        req.cnt_addr  = idx_r;
        req.cnt_we    = pre_ok;
        req.cnt_wdata = alu_sum[CntW-1:0];
      end
      S_U0:  req.heap_addr = IdxW'((cur_r - 1'b1) >> 1);
      S_U1:  req.cnt_addr = rsp.heap_rdata;
      S_U2:  begin
        req.heap_addr = par_r; req.heap_we = alu_gt; req.heap_wdata = idx_r;
        req.slot_addr = pe_r;  req.slot_we = alu_gt; req.slot_wdata = cur_r;
      end
      S_U3:  begin
        req.heap_addr = cur_r; req.heap_we = 1'b1; req.heap_wdata = pe_r;
        req.slot_addr = idx_r; req.slot_we = 1'b1; req.slot_wdata = par_r;
      end
      S_D0:  req.heap_addr = lz_w[IdxW-1:0];
      S_D1:  req.cnt_addr = rsp.heap_rdata;
      S_D2:  req.heap_addr = IdxW'(rz_w);
      S_D3:  req.cnt_addr = rsp.heap_rdata;
      S_DS0: begin
        req.heap_addr = cur_r; req.heap_we = 1'b1; req.heap_wdata = ce_r;
        req.slot_addr = ce_r;  req.slot_we = 1'b1; req.slot_wdata = cur_r;
      end
      S_DS1: begin
        req.heap_addr = cz_r;  req.heap_we = 1'b1; req.heap_wdata = idx_r;
        req.slot_addr = idx_r; req.slot_we = 1'b1; req.slot_wdata = cz_r;
      end
      S_T0:  req.heap_addr = '0;
      S_T1:  req.cnt_addr = rsp.heap_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (go) begin
          type_r <= req_type;
          idx_r  <= entry_index;
          if ({1'b0, entry_index} >= active) begin
            status_r <= 1'b1;
            now_r    <= '0;
            state_r  <= S_T0;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD:  state_r <= S_CHK;
        S_CHK: begin
          if (!pre_ok) begin
            status_r <= 1'b1;
            now_r    <= rsp.cnt_rdata;
            state_r  <= S_T0;
          end else begin
            status_r  <= 1'b0;
            now_r     <= alu_sum[CntW-1:0];
            cur_cnt_r <= alu_sum[CntW-1:0];
            cur_r     <= rsp.slot_rdata;
            state_r   <= (type_r == ReqInc || type_r == ReqEmp) ? S_U0 : S_D0;
          end
        end
        S_U0: begin
          par_r   <= IdxW'((cur_r - 1'b1) >> 1);
          state_r <= (cur_r == '0) ? S_T0 : S_U1;
        end
        S_U1: begin pe_r <= rsp.heap_rdata; state_r <= S_U2; end
        S_U2: state_r <= alu_gt ? S_U3 : S_T0;
        S_U3: begin cur_r <= par_r; state_r <= S_U0; end
        S_D0: begin
          lz_r    <= lz_w[IdxW-1:0];
          state_r <= (lz_w >= active) ? S_T0 : S_D1;
        end
        S_D1: begin le_r <= rsp.heap_rdata; state_r <= S_D2; end
        S_D2: begin
          lc_r <= rsp.cnt_rdata;
          if (rz_w >= {1'b0, active}) begin
            // Only a left child: swap once if it is strictly greater.
            ce_r    <= le_r;
            cz_r    <= lz_r;
            state_r <= alu_gt ? S_DS0 : S_T0;
          end else begin
            state_r <= S_D3;
          end
        end
        S_D3: begin re_r <= rsp.heap_rdata; state_r <= S_D4; end
        S_D4: begin
          rc_r    <= rsp.cnt_rdata;
          lgtr_r  <= alu_gt;
          state_r <= S_D5;
        end
        S_D5: begin
          ce_r    <= lgtr_r ? le_r : re_r;
          cz_r    <= lgtr_r ? lz_r : lz_r + 1'b1;
          state_r <= alu_gt ? S_DS0 : S_T0;
        end
        S_DS0: state_r <= S_DS1;
        S_DS1: begin cur_r <= cz_r; state_r <= S_D0; end
        S_T0:  state_r <= S_T1;
        S_T1:  begin te_r <= rsp.heap_rdata; state_r <= S_T2; end
        S_T2:  begin
          top_e_r <= te_r;
          top_c_r <= rsp.cnt_rdata;
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle          = (state_r == S_IDLE);
  assign res_valid     = valid_r;
  assign res_status    = status_r;
  assign res_now       = now_r;
  assign res_top_entry = top_e_r;
  assign res_top_count = top_c_r;
endmodule

FILE: hdl/indexed_max_heap_count_tracker.sv
// Top level of the indexed max-heap count tracker: configuration registers,
// memories and sequencer. Depends on ihc_pkg, ihc_store and ihc_seq.
//
// A request is transferred when start is high and busy is low; it carries a
// request type and an entry index. Exactly one result follows, shown for a
// single cycle with out_valid high: a status, the entry's new count and the
// entry and count at the heap root. The receiver cannot stall it.
// An out-of-range index goes straight to the root readout, a refused request
// to it after the count check. A rise climbs until it reaches the root or a
// parent that is not smaller; a fall descends until no child is strictly
// greater. A fall costs more per level, so with a 1024-entry heap the longest
// request is a fall from the root to the deepest level. Each level takes
// several single-port memory accesses and one or more shared-compare passes.
// busy stays high for the whole request and drops in the result cycle, so the
// next request may be transferred at the edge that takes the result.
// The configuration channel is always ready. Writing the heap size restores
// all counts and the heap order, as does reset: all 1024 entries of the
// memories are swept, with busy high, before the first request is taken.
module indexed_max_heap_count_tracker import ihc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_req_type,
  input  logic [IdxW-1:0]        in_entry_index,
  output logic                   out_valid,
  output logic                   out_status,
  output logic signed [CntW-1:0] out_entry_count_now,
  output logic [IdxW-1:0]        out_top_entry,
  output logic signed [CntW-1:0] out_top_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [SizeW-1:0]       cfg_data
);
  logic [SizeW-1:0] active_r;
  logic [OffW-1:0]  offset_r;
  logic             clear_req, clearing, seq_idle;
  mem_req_t         req;
  mem_rsp_t         rsp;

  assign cfg_ready = 1'b1;
  assign clear_req = cfg_valid && (cfg_index == CfgActive);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= SizeW'(81);
      offset_r <= OffW'(10);
    end else if (cfg_valid) begin
      if (cfg_index == CfgActive) begin
        if (cfg_data == '0) active_r <= SizeW'(1);
        else if (cfg_data > SizeW'(MaxEntries)) active_r <= SizeW'(MaxEntries);
        else active_r <= cfg_data;
      end else begin
        offset_r <= cfg_data[OffW-1:0];
      end
    end
  end

  ihc_store u_store (
    .clk(clk), .rst_n(rst_n), .clear_req(clear_req),
    .req(req), .rsp(rsp), .clearing(clearing)
  );

  ihc_seq u_seq (
    .clk(clk), .rst_n(rst_n), .go(start && !busy),
    .req_type(in_req_type), .entry_index(in_entry_index),
    .active(active_r), .offset(offset_r), .rsp(rsp), .req(req), .idle(seq_idle),
    .res_valid(out_valid), .res_status(out_status), .res_now(out_entry_count_now),
    .res_top_entry(out_top_entry), .res_top_count(out_top_count)
  );

  assign busy = !seq_idle || clearing;
endmodule

FILE: hdl/ihc_checker.sv
// Port-level checks for the indexed max-heap count tracker, bound to the top.
// Depends on ihc_pkg and indexed_max_heap_count_tracker.
module ihc_checker import ihc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_status,
  input logic signed [CntW-1:0] out_entry_count_now
);
  // A transferred request keeps the block busy until its result.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after a request");

  // A result is a single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted two cycles");

  // The result arrives as the block becomes free again.
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy still high with a result");

  // A result must follow a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a request");

  // The status and count of a result are always fully defined.
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_status, out_entry_count_now}))
    else $error("result carries unknown bits");
endmodule

bind indexed_max_heap_count_tracker ihc_checker u_ihc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_entry_count_now(out_entry_count_now)
);
